[hw/rtl/glca_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glca_pkg
// Shared constants, memory request and response types for the growing-tree
// nearest-living common ancestor block.
// ----------------------------------------------------------------------------
package glca_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 11;
    localparam int LVL_W      = 4;
    localparam int CNT_W      = 11;
    localparam int JMP_DEPTH  = MAX_NODES * LOG_LEVELS;
    localparam int JMP_AW     = 14;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [LVL_W-1:0]   lvl_t;

    typedef struct packed {
        node_t  jmp_rnode;
        lvl_t   jmp_rlvl;
        logic   jmp_we;
        node_t  jmp_wnode;
        lvl_t   jmp_wlvl;
        node_t  jmp_wdata;
        node_t  dep_rnode;
        logic   dep_we;
        node_t  dep_wnode;
        depth_t dep_wdata;
        node_t  rdr_rnode;
        logic   rdr_we;
        node_t  rdr_wnode;
        node_t  rdr_wdata;
    } mem_req_t;

    typedef struct packed {
        node_t  jmp;
        depth_t dep;
        node_t  rdr;
    } mem_rsp_t;

    function automatic logic [JMP_AW-1:0] jmp_addr(input node_t n, input lvl_t l);
        logic [JMP_AW-1:0] base;
        base = JMP_AW'(n) * JMP_AW'(LOG_LEVELS);
        return base + JMP_AW'(l);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/glca_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glca_mem
// Ancestor jump table, depth table and redirect table, each with one write
// port and one registered read port. The root reads as all zeros.
// ----------------------------------------------------------------------------
module glca_mem (
    input  wire logic              clk,
    input  wire glca_pkg::mem_req_t req,
    output glca_pkg::mem_rsp_t     rsp
);
    import glca_pkg::*;

    node_t  jmp_mem [JMP_DEPTH];
    depth_t dep_mem [MAX_NODES];
    node_t  rdr_mem [MAX_NODES];

    node_t  jmp_q_reg;
    depth_t dep_q_reg;
    node_t  rdr_q_reg;
    logic   jmp_zero_reg;
    logic   dep_zero_reg;
    logic   rdr_zero_reg;

    always_ff @(posedge clk)
    begin
        if (req.jmp_we)
        begin
            jmp_mem[jmp_addr(req.jmp_wnode, req.jmp_wlvl)] <= req.jmp_wdata;
        end
        if (req.dep_we)
        begin
            dep_mem[req.dep_wnode] <= req.dep_wdata;
        end
        if (req.rdr_we)
        begin
            rdr_mem[req.rdr_wnode] <= req.rdr_wdata;
        end
        jmp_q_reg    <= jmp_mem[jmp_addr(req.jmp_rnode, req.jmp_rlvl)];
        dep_q_reg    <= dep_mem[req.dep_rnode];
        rdr_q_reg    <= rdr_mem[req.rdr_rnode];
        jmp_zero_reg <= (req.jmp_rnode == '0);
        dep_zero_reg <= (req.dep_rnode == '0);
        rdr_zero_reg <= (req.rdr_rnode == '0);
    end

    // The root is never written by an add, and every table read for it returns zero.
    assign rsp.jmp = jmp_zero_reg ? '0 : jmp_q_reg;
    assign rsp.dep = dep_zero_reg ? '0 : dep_q_reg;
    assign rsp.rdr = rdr_zero_reg ? '0 : rdr_q_reg;

endmodule
`default_nettype wire

[hw/rtl/growing_tree_lca_with_deletion.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// growing_tree_lca_with_deletion
// Growing rooted tree with leaf add, node removal and nearest-living lowest
// common ancestor queries by binary lifting over synchronous table memories.
// ----------------------------------------------------------------------------
// An add writes depth, redirect and parent, then each jump level; a remove sets
// the redirect to the parent; a query lifts the deeper node, then both unless one
// is the other's ancestor, then follows redirects; each step waits on one table read.
// done is a one-cycle strobe in the first idle cycle; the receiver cannot stall it.
// One transaction at a time; a dropped add or an unused opcode leaves busy low.
// Reset leaves the tree as the single root node 0.
module growing_tree_lca_with_deletion (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            op,
    input  wire glca_pkg::node_t       node_a,
    input  wire glca_pkg::node_t       node_b,
    output logic                       done,
    output glca_pkg::node_t            ancestor
);
    import glca_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_AD, S_AW, S_AJ, S_AJW, S_RM, S_RMW,
        S_QA, S_QB, S_QSW, S_L1J, S_L1D, S_L1C, S_EQ,
        S_L2A, S_L2B, S_L2C, S_L2F, S_L2G, S_RD, S_RC
    } state_t;

    state_t   state_reg, state_next;
    node_t    a_reg, a_next;
    node_t    b_reg, b_next;
    depth_t   da_reg, da_next;
    depth_t   db_reg, db_next;
    lvl_t     k_reg, k_next;
    node_t    up_reg, up_next;
    node_t    n_reg, n_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic     done_reg, done_next;
    node_t    anc_reg, anc_next;

    mem_req_t req;
    mem_rsp_t rsp;

    glca_mem u_mem (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        k_next     = k_reg;
        up_next    = up_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        done_next  = 1'b0;
        anc_next   = anc_reg;
        req        = '0;
        req.jmp_rnode = a_reg;
        req.jmp_rlvl  = k_reg;
        req.dep_rnode = a_reg;
        req.rdr_rnode = a_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next = node_a;
                    b_next = node_b;
                    if (op == OP_ADD)
                    begin
                        if (cnt_reg < CNT_W'(MAX_NODES - 1))
                        begin
                            cnt_next   = cnt_reg + 1'b1;
                            n_next     = NODE_W'(cnt_reg + 1'b1);
                            state_next = S_AD;
                        end
                    end
                    else if (op == OP_REMOVE)
                    begin
                        state_next = S_RM;
                    end
                    else if (op == OP_QUERY)
                    begin
                        state_next = S_QA;
                    end
                end
            end
            S_AD:
            begin
                req.dep_rnode = a_reg;
                state_next    = S_AW;
            end
            S_AW:
            begin
                req.dep_we    = 1'b1;
                req.dep_wnode = n_reg;
                req.dep_wdata = rsp.dep + 1'b1;
                req.rdr_we    = 1'b1;
                req.rdr_wnode = n_reg;
                req.rdr_wdata = n_reg;
                req.jmp_we    = 1'b1;
                req.jmp_wnode = n_reg;
                req.jmp_wlvl  = '0;
                req.jmp_wdata = a_reg;
                up_next       = a_reg;
                k_next        = LVL_W'(1);
                state_next    = (LOG_LEVELS > 1) ? S_AJ : S_IDLE;
            end
            S_AJ:
            begin
                req.jmp_rnode = up_reg;
                req.jmp_rlvl  = k_reg - 1'b1;
                state_next    = S_AJW;
            end
            S_AJW:
            begin
                req.jmp_we    = 1'b1;
                req.jmp_wnode = n_reg;
                req.jmp_wlvl  = k_reg;
                req.jmp_wdata = rsp.jmp;
                up_next       = rsp.jmp;
                if (k_reg == LVL_W'(LOG_LEVELS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_AJ;
                end
            end
            S_RM:
            begin
                req.jmp_rnode = a_reg;
                req.jmp_rlvl  = '0;
                state_next    = S_RMW;
            end
            S_RMW:
            begin
                req.rdr_we    = 1'b1;
                req.rdr_wnode = a_reg;
                req.rdr_wdata = rsp.jmp;
                state_next    = S_IDLE;
            end
            S_QA:
            begin
                req.dep_rnode = a_reg;
                state_next    = S_QB;
            end
            S_QB:
            begin
                da_next       = rsp.dep;
                req.dep_rnode = b_reg;
                state_next    = S_QSW;
            end
            S_QSW:
            begin
                // Make a the deeper node; db holds the depth of the shallower one.
                if (rsp.dep > da_reg)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    db_next = da_reg;
                end
                else
                begin
                    db_next = rsp.dep;
                end
                k_next     = LVL_W'(LOG_LEVELS - 1);
                state_next = S_L1J;
            end
            S_L1J:
            begin
                req.jmp_rnode = a_reg;
                req.jmp_rlvl  = k_reg;
                state_next    = S_L1D;
            end
            S_L1D:
            begin
                up_next       = rsp.jmp;
                req.dep_rnode = rsp.jmp;
                state_next    = S_L1C;
            end
            S_L1C:
            begin
                if (rsp.dep >= db_reg)
                begin
                    a_next = up_reg;
                end
                if (k_reg == '0)
                begin
                    state_next = S_EQ;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_L1J;
                end
            end
            S_EQ:
            begin
                if (a_reg == b_reg)
                begin
                    anc_next   = a_reg;
                    steps_next = '0;
                    state_next = S_RD;
                end
                else
                begin
                    k_next     = LVL_W'(LOG_LEVELS - 1);
                    state_next = S_L2A;
                end
            end
            S_L2A:
            begin
                req.jmp_rnode = a_reg;
                req.jmp_rlvl  = k_reg;
                state_next    = S_L2B;
            end
            S_L2B:
            begin
                up_next       = rsp.jmp;
                req.jmp_rnode = b_reg;
                req.jmp_rlvl  = k_reg;
                state_next    = S_L2C;
            end
            S_L2C:
            begin
                if (up_reg != rsp.jmp)
                begin
                    a_next = up_reg;
                    b_next = rsp.jmp;
                end
                if (k_reg == '0)
                begin
                    state_next = S_L2F;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_L2A;
                end
            end
            S_L2F:
            begin
                req.jmp_rnode = a_reg;
                req.jmp_rlvl  = '0;
                state_next    = S_L2G;
            end
            S_L2G:
            begin
                anc_next   = rsp.jmp;
                steps_next = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                req.rdr_rnode = anc_reg;
                state_next    = S_RC;
            end
            S_RC:
            begin
                // The walk gives up after one step per table entry.
                if (rsp.rdr == anc_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    anc_next   = rsp.rdr;
                    steps_next = steps_reg + 1'b1;
                    if (steps_reg == CNT_W'(MAX_NODES - 1))
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            anc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            anc_reg   <= anc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        k_reg     <= k_next;
        up_reg    <= up_next;
        n_reg     <= n_next;
        steps_reg <= steps_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign ancestor = anc_reg;

endmodule
`default_nettype wire

[tb/sv/growing_tree_lca_with_deletion_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// growing_tree_lca_with_deletion_tb
// Drives adds, removes and queries into the tree block, keeps its own copy of
// the tree to predict every query answer, and compares each done strobe with
// the oldest predicted ancestor.
// ----------------------------------------------------------------------------
module growing_tree_lca_with_deletion_tb;
    import glca_pkg::*;

    typedef struct packed {
        logic [1:0] op;
        node_t      a;
        node_t      b;
    } cmd_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [1:0] op;
    node_t      node_a;
    node_t      node_b;
    logic       busy;
    logic       done;
    node_t      ancestor;

    growing_tree_lca_with_deletion dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .node_a(node_a), .node_b(node_b), .done(done), .ancestor(ancestor)
    );

    // Shadow copy of the tree.
    node_t  jumps [MAX_NODES][LOG_LEVELS];
    depth_t depth_of [MAX_NODES];
    node_t  link_of [MAX_NODES];
    int     added;

    cmd_t   pending [$];
    node_t  expected_ancestors [$];
    int     idle_pct;
    bit     hold_off;
    int     errors;
    int     quiet_cycles;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic node_t lowest_common(input node_t x, input node_t y);
        node_t t;
        if (depth_of[y] > depth_of[x])
        begin
            t = x;
            x = y;
            y = t;
        end
        for (int k = LOG_LEVELS - 1; k >= 0; k--)
            if (depth_of[jumps[x][k]] >= depth_of[y])
                x = jumps[x][k];
        if (x == y)
            return x;
        for (int k = LOG_LEVELS - 1; k >= 0; k--)
            if (jumps[x][k] != jumps[y][k])
            begin
                x = jumps[x][k];
                y = jumps[y][k];
            end
        return jumps[x][0];
    endfunction

    function automatic node_t living_ancestor(input node_t x);
        for (int s = 0; s < MAX_NODES; s++)
        begin
            if (link_of[x] == x)
                break;
            x = link_of[x];
        end
        return x;
    endfunction

    // Updates the shadow tree and queues an answer for each query.
    function automatic void apply_command(input cmd_t c);
        int n;
        if (c.op == OP_ADD)
        begin
            if (int'(c.a) < MAX_NODES && added + 1 < MAX_NODES)
            begin
                n = added + 1;
                added = n;
                link_of[n] = node_t'(n);
                depth_of[n] = depth_of[c.a] + 1'b1;
                jumps[n][0] = c.a;
                for (int k = 1; k < LOG_LEVELS; k++)
                    jumps[n][k] = jumps[jumps[n][k-1]][k-1];
            end
        end
        else if (c.op == OP_REMOVE)
            link_of[c.a] = jumps[c.a][0];
        else if (c.op == OP_QUERY)
            expected_ancestors.insert(expected_ancestors.size(),
                                      living_ancestor(lowest_common(c.a, c.b)));
    endfunction

    function automatic node_t any_node();
        return node_t'($urandom_range(added, 0));
    endfunction

    task automatic push_cmd(input logic [1:0] o, input node_t a, input node_t b);
        pending.insert(pending.size(), cmd_t'({o, a, b}));
    endtask

    // Sampled away from the rising edge so that the driver's updates have settled.
    task automatic drain();
        while (pending.size() != 0 || start || busy)
            @(negedge clk);
        while (expected_ancestors.size() != 0)
            @(negedge clk);
    endtask

    // Driver: one command is offered at a time, held until busy is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= OP_ADD;
            node_a <= '0;
            node_b <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
                apply_command({op, node_a, node_b});
            if (pending.size() != 0 && !hold_off && $urandom_range(99, 0) >= idle_pct)
            begin
                {op, node_a, node_b} <= pending.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_ancestors.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, ancestor);
                    errors++;
                end
                else
                begin
                    if (ancestor !== expected_ancestors[0])
                    begin
                        $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                                 $time, expected_ancestors[0], ancestor);
                        errors++;
                    end
                    void'(expected_ancestors.pop_front());
                end
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        node_t x;
        rst_n = 1'b0;
        idle_pct = 0;
        hold_off = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        added = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            depth_of[i] = '0;
            link_of[i] = '0;
            for (int k = 0; k < LOG_LEVELS; k++)
                jumps[i][k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: root queries, root removal, a chain, siblings, unused opcode.
        push_cmd(OP_QUERY, 10'd0, 10'd0);
        push_cmd(OP_REMOVE, 10'd0, 10'h3FF);
        push_cmd(OP_QUERY, 10'd0, 10'd0);
        push_cmd(OP_ADD, 10'd0, 10'h3FF);
        push_cmd(OP_ADD, 10'd1, 10'd0);
        push_cmd(OP_ADD, 10'd2, 10'd0);
        push_cmd(OP_ADD, 10'd1, 10'd0);
        push_cmd(OP_ADD, 10'd0, 10'd0);
        push_cmd(OP_QUERY, 10'd3, 10'd4);
        push_cmd(OP_QUERY, 10'd3, 10'd5);
        push_cmd(OP_QUERY, 10'd3, 10'd3);
        push_cmd(OP_QUERY, 10'd2, 10'd3);
        push_cmd(2'd3, 10'h3FF, 10'h3FF);
        push_cmd(OP_REMOVE, 10'd1, 10'd0);
        push_cmd(OP_QUERY, 10'd3, 10'd4);
        push_cmd(OP_REMOVE, 10'd2, 10'd0);
        push_cmd(OP_QUERY, 10'd3, 10'd2);
        push_cmd(OP_QUERY, 10'd4, 10'd5);
        drain();

        // Random phases with different idle rates; a hold-off between phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 57 : (ph == 3) ? 33 : 0;
            for (int i = 0; i < 90; i++)
            begin
                r = $urandom_range(99, 0);
                // Nodes are taken from those already predicted to exist.
                x = node_t'($urandom_range(added + pending.size(), 0));
                if (x > added)
                    x = node_t'(added);
                if (r < 35)
                    push_cmd(OP_ADD, x, node_t'($urandom));
                else if (r < 50)
                    push_cmd(OP_REMOVE, x, node_t'($urandom));
                else if (r < 95)
                    push_cmd(OP_QUERY, x, any_node());
                else
                    push_cmd(2'd3, node_t'($urandom), node_t'($urandom));
                if (pending.size() > 4)
                    while (pending.size() > 1)
                        @(posedge clk);
            end
            drain();
            hold_off = 1'b1;
            repeat (100) @(posedge clk);
            hold_off = 1'b0;
        end

        // A deep chain to exercise lifting over several levels.
        idle_pct = 0;
        for (int i = 0; i < 40; i++)
        begin
            push_cmd(OP_ADD, node_t'(added), 10'd0);
            drain();
        end
        push_cmd(OP_QUERY, node_t'(added), 10'd1);
        push_cmd(OP_QUERY, 10'd1, node_t'(added));
        drain();
        for (int i = 0; i < 8; i++)
        begin
            push_cmd(OP_ADD, node_t'(added), 10'd0);
            push_cmd(OP_REMOVE, node_t'(added), 10'h3FF);
            push_cmd(OP_QUERY, node_t'(added), 10'h3FF);
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/glca_pkg.sv
hw/rtl/glca_mem.sv
hw/rtl/growing_tree_lca_with_deletion.sv
tb/sv/growing_tree_lca_with_deletion_tb.sv
